/* rtl/pwrd_pkg.sv */
// Shared types, constants and register indexes of the pulse width remote decoder.
// No dependencies; every other file of the block depends on this package.
`timescale 1ns / 1ps
`default_nettype none

package pwrd_pkg;

   // Field widths.
   localparam int WIDTH_W   = 16;
   localparam int CODE_W    = 24;
   localparam int COUNT_W   = 8;
   localparam int SHIFT_W   = CODE_W + 1;
   localparam int CSR_IDX_W = 2;

   // Frame and counter limits.
   localparam logic [COUNT_W-1:0] FRAME_BITS = 8'd24;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'd255;
   localparam logic [COUNT_W-1:0] REPEAT_MAX = 8'd250;
   localparam logic [CODE_W-1:0]  ID_MASK    = 24'hFFFFF0;

   // Register reset values.
   localparam logic [WIDTH_W-1:0] SYNC_WIDTH_RST    = 16'd300;
   localparam logic [WIDTH_W-1:0] MIN_BIT_WIDTH_RST = 16'd20;
   localparam logic [WIDTH_W-1:0] MAX_BIT_WIDTH_RST = 16'd150;
   localparam logic [WIDTH_W-1:0] ONE_THRESHOLD_RST = 16'd60;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYNC_WIDTH    = 2'd0,
      CSR_MIN_BIT_WIDTH = 2'd1,
      CSR_MAX_BIT_WIDTH = 2'd2,
      CSR_ONE_THRESHOLD = 2'd3
   } csr_index_type;

   // Timing limits handed from the register file to the decoder.
   typedef struct packed {
      logic [WIDTH_W-1:0] sync_width;
      logic [WIDTH_W-1:0] min_bit_width;
      logic [WIDTH_W-1:0] max_bit_width;
      logic [WIDTH_W-1:0] one_threshold;
   } cfg_type;

   // One decoded result.
   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic               repeated;
      logic [COUNT_W-1:0] repeat_count;
   } result_type;

endpackage

`default_nettype wire

/* rtl/pwrd_if.sv */
// Channel interfaces of the pulse width remote decoder: edge input, result output
// and register write port. Depends on pwrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Edge beats: polarity and width since the previous edge.
interface pwrd_req_if;
   logic                         valid;
   logic                         ready;
   logic                         sync_edge;
   logic [pwrd_pkg::WIDTH_W-1:0] pulse_width;

   modport source (output valid, output sync_edge, output pulse_width, input ready);
   modport sink   (input valid, input sync_edge, input pulse_width, output ready);
endinterface

// Result beats: decoded code with its repeat information.
interface pwrd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pwrd_pkg::CODE_W-1:0]  code;
   logic                         repeated;
   logic [pwrd_pkg::COUNT_W-1:0] repeat_count;

   modport source (output valid, output code, output repeated, output repeat_count,
                   input ready);
   modport sink   (input valid, input code, input repeated, input repeat_count,
                   output ready);
endinterface

// Register write beats.
interface pwrd_csr_if;
   logic                           valid;
   logic                           ready;
   logic [pwrd_pkg::CSR_IDX_W-1:0] index;
   logic [pwrd_pkg::WIDTH_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/pwrd_csr.sv */
// Register file holding the four timing limits of the decoder.
// Depends on pwrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwrd_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [pwrd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [pwrd_pkg::WIDTH_W-1:0]   csr_data,
   output      pwrd_pkg::cfg_type              cfg
);
   import pwrd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;

   // Decode the register index of a write beat.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_SYNC_WIDTH:    cfg_in.sync_width    = csr_data;
            CSR_MIN_BIT_WIDTH: cfg_in.min_bit_width = csr_data;
            CSR_MAX_BIT_WIDTH: cfg_in.max_bit_width = csr_data;
            CSR_ONE_THRESHOLD: cfg_in.one_threshold = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_width    <= SYNC_WIDTH_RST;
         cfg_ff.min_bit_width <= MIN_BIT_WIDTH_RST;
         cfg_ff.max_bit_width <= MAX_BIT_WIDTH_RST;
         cfg_ff.one_threshold <= ONE_THRESHOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/pwrd_core.sv */
// Edge input register and frame decoder: shift register, bit count and repeat
// tracking, updated once per edge beat. Depends on pwrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwrd_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pwrd_pkg::cfg_type            cfg,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic                         req_sync_edge,
   input  wire logic [pwrd_pkg::WIDTH_W-1:0] req_pulse_width,
   input  wire logic                         res_space,
   output      logic                         res_valid,
   output      pwrd_pkg::result_type         res
);
   import pwrd_pkg::*;

   // Input register.
   logic               in_valid_ff;
   logic               in_valid_in;
   logic               in_sync_ff;
   logic [WIDTH_W-1:0] in_width_ff;

   // Decoder state.
   logic [SHIFT_W-1:0] shift_ff;
   logic [SHIFT_W-1:0] shift_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [CODE_W-1:0]  last_code_ff;
   logic [CODE_W-1:0]  last_code_in;
   logic [COUNT_W-1:0] same_ff;
   logic [COUNT_W-1:0] same_in;

   logic               advance;
   logic               req_accept;
   logic [CODE_W-1:0]  frame;
   logic               same;
   logic               frame_end;
   logic               emit;

   // An edge without a result is decoded at once; one with a result waits
   // until the output register has room for it.
   assign advance    = in_valid_ff && (!emit || res_space);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_sync_ff  <= req_sync_edge;
         in_width_ff <= req_pulse_width;
      end
   end

   // Frame end: a long sync edge after more than a full frame of bits.
   assign frame     = shift_ff[SHIFT_W-1:1];
   assign same      = (frame == last_code_ff);
   assign frame_end = in_sync_ff && (in_width_ff > cfg.sync_width) && (count_ff > FRAME_BITS);
   assign emit      = frame_end && ((frame & ID_MASK) != '0);

   // Next decoder state for the held edge.
   always_comb begin
      shift_in     = shift_ff;
      count_in     = count_ff;
      last_code_in = last_code_ff;
      same_in      = same_ff;
      if (!in_sync_ff) begin
         if ((in_width_ff < cfg.min_bit_width) || (in_width_ff > cfg.max_bit_width)) begin
            // A data edge out of range drops the partial frame.
            shift_in = '0;
            count_in = '0;
            same_in  = '0;
         end else begin
            shift_in = {shift_ff[SHIFT_W-2:0], (in_width_ff > cfg.one_threshold)};
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
         end
      end else if (frame_end) begin
         if (emit) begin
            if (same) begin
               if (same_ff < REPEAT_MAX) begin
                  same_in = same_ff + 1'b1;
               end else begin
                  same_in = REPEAT_MAX;
               end
            end else begin
               same_in      = '0;
               last_code_in = frame;
            end
         end
         shift_in = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= '0;
         count_ff     <= '0;
         last_code_ff <= '0;
         same_ff      <= '0;
      end else if (advance) begin
         shift_ff     <= shift_in;
         count_ff     <= count_in;
         last_code_ff <= last_code_in;
         same_ff      <= same_in;
      end
   end

   // Result handed to the output register.
   assign res_valid        = advance && emit;
   assign res.code         = frame;
   assign res.repeated     = same;
   assign res.repeat_count = same_in;

endmodule

`default_nettype wire

/* rtl/pwrd_out.sv */
// Output register of the decoder: holds one result beat until the receiver takes it.
// Depends on pwrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwrd_out (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         res_valid,
   input  wire pwrd_pkg::result_type         res,
   output      logic                         res_space,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic [pwrd_pkg::CODE_W-1:0]  rsp_code,
   output      logic                         rsp_repeated,
   output      logic [pwrd_pkg::COUNT_W-1:0] rsp_repeat_count
);
   import pwrd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   // Room for a new result when empty or when the held one leaves this cycle.
   assign res_space = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (res_valid) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         data_ff <= res;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_code         = data_ff.code;
   assign rsp_repeated     = data_ff.repeated;
   assign rsp_repeat_count = data_ff.repeat_count;

endmodule

`default_nettype wire

/* rtl/pulse_width_remote_decoder.sv */
// Top level of the pulse width remote decoder.
// Depends on pwrd_pkg, pwrd_if, pwrd_csr, pwrd_core and pwrd_out.
//
// Usage:
// The req_bus channel carries one beat per pin edge: sync_edge (1 for a high
// level edge that may end a frame, 0 for a data edge) and pulse_width, the time
// since the previous edge in 10 us ticks. Data edges within the bit width limits
// shift one bit into the frame; a long sync edge after more than 24 bits ends
// the frame, and a code with a nonzero address part leaves on rsp_bus together
// with its repeat flag and a repeat count that saturates at 250.
// The csr_bus channel writes the four timing limits (sync width, minimum and
// maximum bit width, one threshold); it is always ready and should be used only
// while no edge is in flight.
// An accepted edge beat waits in the edge input register and its result beat in the
// output register. One edge beat is accepted every cycle unless a held edge's result
// waits for room; the rate is set by the single decode stage between the two registers.
// Reset restores the default limits and clears the frame, the last code and the
// repeat count. When the receiver stalls, the output register holds its beat;
// the edge register still decodes edges that produce no result, and an edge
// waits in it only when its result would find the output register full.
`timescale 1ns / 1ps
`default_nettype none

module pulse_width_remote_decoder (
   input wire logic  clock,
   input wire logic  reset,
   pwrd_req_if.sink  req_bus,
   pwrd_rsp_if.source rsp_bus,
   pwrd_csr_if.sink  csr_bus
);
   import pwrd_pkg::*;

   cfg_type    cfg;
   logic       res_space;
   logic       res_valid;
   result_type res;

   // Timing limit registers.
   pwrd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_bus.valid),
      .csr_ready (csr_bus.ready),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.data),
      .cfg       (cfg)
   );

   // Edge register and frame decoder.
   pwrd_core u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_bus.valid),
      .req_ready       (req_bus.ready),
      .req_sync_edge   (req_bus.sync_edge),
      .req_pulse_width (req_bus.pulse_width),
      .res_space       (res_space),
      .res_valid       (res_valid),
      .res             (res)
   );

   // Result register.
   pwrd_out u_out (
      .clock            (clock),
      .reset            (reset),
      .res_valid        (res_valid),
      .res              (res),
      .res_space        (res_space),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_code         (rsp_bus.code),
      .rsp_repeated     (rsp_bus.repeated),
      .rsp_repeat_count (rsp_bus.repeat_count)
   );

endmodule

`default_nettype wire

/* rtl/pwrd_checker.sv */
// Port level checks of the pulse width remote decoder, bound to the top level.
// Depends on pwrd_pkg and on the top level's channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module pwrd_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [pwrd_pkg::CODE_W-1:0]  rsp_code,
   input wire logic                         rsp_repeated,
   input wire logic [pwrd_pkg::COUNT_W-1:0] rsp_repeat_count
);
   import pwrd_pkg::*;

   // No result beat is shown right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   // A stalled result beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code) &&
                                  $stable(rsp_repeated) && $stable(rsp_repeat_count))
      else $error("stalled result beat changed");

   // The repeat count saturates at its limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_repeat_count <= REPEAT_MAX)
      else $error("repeat count above its limit");

   // A new code restarts the repeat count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_repeated |-> rsp_repeat_count == '0)
      else $error("new code with nonzero repeat count");

   // Codes with an empty address part are never sent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_code & ID_MASK) != '0)
      else $error("empty code sent");

endmodule

bind pulse_width_remote_decoder pwrd_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_code         (rsp_bus.code),
   .rsp_repeated     (rsp_bus.repeated),
   .rsp_repeat_count (rsp_bus.repeat_count)
);

`default_nettype wire
